[design/isqrr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isqrr_pkg
// shared constants, stage type and one step of the bit-pair square root
// ----------------------------------------------------------------------------
package isqrr_pkg;

  localparam int unsigned RadBits       = 32;
  localparam int unsigned RootOutBits   = 17;
  localparam int unsigned Steps         = (RadBits + 1) / 2;
  localparam int unsigned PadBits       = 2 * Steps;
  localparam int unsigned RemBits       = Steps + 3;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned Stages        = (Steps + StepsPerStage - 1) / StepsPerStage;

  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic [Steps-1:0]   root;
    logic [PadBits-1:0] rad;
  } stage_t;

  // one restoring step: bring down a bit pair, try the subtraction
  function automatic stage_t sqrt_step(input stage_t s);
    logic [RemBits-1:0] rem_sh;
    logic [RemBits-1:0] trial;
    stage_t             r;
    rem_sh = {s.rem[RemBits-3:0], s.rad[PadBits-1:PadBits-2]};
    trial  = RemBits'({s.root, 2'b01});
    r.rad  = {s.rad[PadBits-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[Steps-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[Steps-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/integer_square_root_rounded_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_square_root_rounded_unit
// pipeline: 8 stages of two bit-pair steps each, then a rounding stage
// throughput one transaction per cycle; busy_o stays low, the receiver cannot
// stall and the fully pipelined datapath takes a new radicand every cycle
// reset clears the valid bits only; the datapath registers hold no reset
// ----------------------------------------------------------------------------
module integer_square_root_rounded_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [isqrr_pkg::RadBits-1:0]    radicand_i,
  output logic                                  valid_o,
  output logic [isqrr_pkg::RootOutBits-1:0]     root_o
);
  import isqrr_pkg::*;

  stage_t                 stage_q [Stages];
  stage_t                 stage_d [Stages];
  logic   [Stages-1:0]    valid_q;
  stage_t                 first_s;
  logic                   out_valid_q;
  logic [RootOutBits-1:0] root_q;
  logic [RootOutBits-1:0] root_d;

  assign busy_o = 1'b0;

  always_comb begin
    first_s.rem  = '0;
    first_s.root = '0;
    first_s.rad  = PadBits'(radicand_i);
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    always_comb begin
      stage_t t;
      t = (s == 0) ? first_s : stage_q[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < StepsPerStage; k++) begin
        if (s * StepsPerStage + k < Steps) begin
          t = sqrt_step(t);
        end
      end
      stage_d[s] = t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= (s == 0) ? start_i : valid_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      stage_q[s] <= stage_d[s];
    end
  end

  // round up when the remainder exceeds the floor root
  always_comb begin
    if (RemBits'(stage_q[Stages-1].root) < stage_q[Stages-1].rem) begin
      root_d = RootOutBits'(stage_q[Stages-1].root) + RootOutBits'(1);
    end else begin
      root_d = RootOutBits'(stage_q[Stages-1].root);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign valid_o = out_valid_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire
